@@ rtl/cbe_pkg.sv @@
// cbe_pkg: shared constants, side codes and the front-to-back record type
// for the CIGAR breakpoint extractor. No dependencies.
package cbe_pkg;

   localparam int unsigned SYM_W = 8;
   localparam int unsigned POS_W = 31;
   localparam int unsigned LEN_W = 15;
   localparam int unsigned SIDE_W = 3;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [SYM_W-1:0] SYM_M = 8'h4D;   // 'M'
   localparam logic [SYM_W-1:0] SYM_D = 8'h44;   // 'D'
   localparam logic [SYM_W-1:0] SYM_I = 8'h49;   // 'I'
   localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30; // '0'
   localparam logic [SYM_W-1:0] SYM_NINE = 8'h39; // '9'

   // breakpoint side codes
   localparam logic [SIDE_W-1:0] SIDE_CLIP_LEFT = 3'd0;
   localparam logic [SIDE_W-1:0] SIDE_CLIP_RIGHT = 3'd1;
   localparam logic [SIDE_W-1:0] SIDE_BOTH = 3'd2;
   localparam logic [SIDE_W-1:0] SIDE_DEL_LEFT = 3'd3;
   localparam logic [SIDE_W-1:0] SIDE_DEL_RIGHT = 3'd4;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // One record per character that yields results; two_res marks a
   // deletion in indel mode (second result is deletion-right at pos1).
   typedef struct packed {
      logic              bp_valid;
      logic [POS_W-1:0]  pos0;
      logic [POS_W-1:0]  pos1;
      logic [LEN_W-1:0]  len;
      logic [SIDE_W-1:0] side0;
      logic [LEN_W-1:0]  mapped;
      logic              last;
      logic              two_res;
   } rec_type;

endpackage

@@ rtl/cigar_breakpoint_extractor.sv @@
// cigar_breakpoint_extractor: top level; front classifier, record queue and
// result back end. Depends on cbe_pkg, cbe_front, cbe_fifo, cbe_back.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_push / req_full | symbol, first_char, last_char,
//          |           |                     | start_pos, indel_mode
//  rsp_    | out       | rsp_pop / rsp_empty | bp_valid, bp_pos, bp_len, bp_side,
//          |           |                     | mapped_total, last_result
//
// One character is taken per cycle while the record queue is not full; the
// parse state is updated by one multiply-by-ten-and-add or by saturating adds in the front.
// A result passes through the record queue and the back end's result register
// before it is on the rsp_ ports; a deletion in indel mode yields two results
// over two rsp_ transactions, every other result-bearing character one.
// Reset (synchronous) zeroes the parse state and empties the 4-record queue.
// req_full rises when the queue is full, i.e. the consumer has stalled long
// enough (or deletions outpace it) to back up four records.
module cigar_breakpoint_extractor import cbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic              req_first_char,
   input  logic              req_last_char,
   input  logic [POS_W-1:0]  req_start_pos,
   input  logic              req_indel_mode,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_bp_valid,
   output logic [POS_W-1:0]  rsp_bp_pos,
   output logic [LEN_W-1:0]  rsp_bp_len,
   output logic [SIDE_W-1:0] rsp_bp_side,
   output logic [LEN_W-1:0]  rsp_mapped_total,
   output logic              rsp_last_result
);

   // front -> queue
   logic    q_push, q_full;
   rec_type q_wr_rec;
   // queue -> back
   logic    q_pop, q_empty;
   rec_type q_rd_rec;

   // state, classification, one record per result-bearing character
   cbe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_symbol     (req_symbol),
      .req_first_char (req_first_char),
      .req_last_char  (req_last_char),
      .req_start_pos  (req_start_pos),
      .req_indel_mode (req_indel_mode),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_rec          (q_wr_rec)
   );

   // decouples the character stream from result back-pressure
   cbe_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_wr_rec),
      .full     (q_full),
      .pop      (q_pop),
      .pop_rec  (q_rd_rec),
      .empty    (q_empty)
   );

   // expands records into result transactions from a register stage
   cbe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_rec            (q_rd_rec),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_bp_valid     (rsp_bp_valid),
      .rsp_bp_pos       (rsp_bp_pos),
      .rsp_bp_len       (rsp_bp_len),
      .rsp_bp_side      (rsp_bp_side),
      .rsp_mapped_total (rsp_mapped_total),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

@@ rtl/cbe_front.sv @@
// cbe_front: accepts CIGAR characters, keeps the parse state and classifies
// each character into a result record. Depends on cbe_pkg.
module cbe_front import cbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic              req_first_char,
   input  logic              req_last_char,
   input  logic [POS_W-1:0]  req_start_pos,
   input  logic              req_indel_mode,
   input  logic              q_full,
   output logic              q_push,
   output rec_type           q_rec
);

   logic [LEN_W-1:0] run_ff, run_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] msum_ff, msum_in;
   logic             indel_ff, indel_in;

   logic             accept;
   logic [LEN_W-1:0] run_e, msum_e;
   logic [POS_W-1:0] pos_e, pos_adv;
   logic             indel_e;
   logic             is_digit;
   logic [LEN_W+3:0] run_x10;
   logic [POS_W:0]   pos_sum;
   logic [LEN_W:0]   msum_sum;
   logic [LEN_W-1:0] msum_adv;
   logic             has_bp;

   assign accept = req_push && !q_full;
   assign req_full = q_full;

   // first character reloads the state before it is processed
   assign run_e = req_first_char ? '0 : run_ff;
   assign msum_e = req_first_char ? '0 : msum_ff;
   assign pos_e = req_first_char ? req_start_pos : pos_ff;
   assign indel_e = req_first_char ? req_indel_mode : indel_ff;

   assign is_digit = (req_symbol >= SYM_ZERO) && (req_symbol <= SYM_NINE);

   // run * 10 + digit as shifts
   assign run_x10 = {run_e, 3'b000} + {2'b00, run_e, 1'b0}
                  + {{(LEN_W){1'b0}}, 4'(req_symbol - SYM_ZERO)};

   assign pos_sum = {1'b0, pos_e} + {{(POS_W-LEN_W+1){1'b0}}, run_e};
   assign pos_adv = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
   assign msum_sum = {1'b0, msum_e} + {1'b0, run_e};
   assign msum_adv = msum_sum[LEN_W] ? LEN_MAX : msum_sum[LEN_W-1:0];

   always_comb begin
      run_in = run_e;
      pos_in = pos_e;
      msum_in = msum_e;
      indel_in = indel_e;
      has_bp = 1'b0;
      q_rec = '0;
      q_rec.len = run_e;
      q_rec.pos0 = pos_e;
      q_rec.pos1 = pos_adv;
      q_rec.side0 = (msum_e != '0) ? SIDE_CLIP_LEFT : SIDE_CLIP_RIGHT;
      if (is_digit) begin
         run_in = (run_x10 > {4'b0000, LEN_MAX}) ? LEN_MAX : run_x10[LEN_W-1:0];
      end else begin
         run_in = '0;
         if (req_symbol == SYM_M) begin
            pos_in = pos_adv;
            msum_in = msum_adv;
         end else if (req_symbol == SYM_D) begin
            pos_in = pos_adv;
            if (indel_e) begin
               has_bp = 1'b1;
               q_rec.two_res = 1'b1;
               q_rec.side0 = SIDE_DEL_LEFT;
            end
         end else if (indel_e && (req_symbol == SYM_I)) begin
            has_bp = 1'b1;
            q_rec.side0 = SIDE_BOTH;
         end else begin
            has_bp = 1'b1;
         end
      end
      q_rec.bp_valid = has_bp;
      q_rec.last = req_last_char;
      // total after this character; only M adds to it, and M has no breakpoint
      q_rec.mapped = msum_in;
      // bare end result
      if (!has_bp) begin
         q_rec.pos0 = '0;
         q_rec.len = '0;
         q_rec.side0 = SIDE_CLIP_LEFT;
      end
   end

   assign q_push = accept && (has_bp || req_last_char);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         pos_ff <= '0;
         msum_ff <= '0;
         indel_ff <= 1'b0;
      end else if (accept) begin
         run_ff <= run_in;
         pos_ff <= pos_in;
         msum_ff <= msum_in;
         indel_ff <= indel_in;
      end
   end

endmodule

@@ rtl/cbe_fifo.sv @@
// cbe_fifo: short record queue between front and back.
// Depends on cbe_pkg.
module cbe_fifo import cbe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output rec_type pop_rec,
   output logic    empty
);

   rec_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("fifo count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fifo count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("fifo count did not shrink on pop");

endmodule

@@ rtl/cbe_back.sv @@
// cbe_back: expands queued records into one or two result transactions and
// holds the current result in registers. Depends on cbe_pkg.
module cbe_back import cbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  rec_type           q_rec,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_bp_valid,
   output logic [POS_W-1:0]  rsp_bp_pos,
   output logic [LEN_W-1:0]  rsp_bp_len,
   output logic [SIDE_W-1:0] rsp_bp_side,
   output logic [LEN_W-1:0]  rsp_mapped_total,
   output logic              rsp_last_result
);

   rec_type cur_ff, cur_in;
   logic    valid_ff, valid_in;
   logic    phase_ff, phase_in;
   logic    finish, take;

   // record is done when its final result is taken
   assign finish = valid_ff && rsp_pop && (!cur_ff.two_res || phase_ff);
   assign take = !valid_ff || finish;
   assign q_pop = take && !q_empty;

   always_comb begin
      cur_in = cur_ff;
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (take) begin
         cur_in = q_rec;
         valid_in = !q_empty;
         phase_in = 1'b0;
      end else if (valid_ff && rsp_pop) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_bp_valid = cur_ff.bp_valid;
   assign rsp_bp_pos = phase_ff ? cur_ff.pos1 : cur_ff.pos0;
   assign rsp_bp_len = cur_ff.len;
   assign rsp_bp_side = phase_ff ? SIDE_DEL_RIGHT : cur_ff.side0;
   assign rsp_mapped_total = cur_ff.mapped;
   assign rsp_last_result = cur_ff.last && (phase_ff || !cur_ff.two_res);

   a_phase_two: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (valid_ff && cur_ff.two_res))
      else $error("second phase without a two-result record");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (finish && q_empty) |=> rsp_empty)
      else $error("result shown after queue drained");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_bp_pos)
                                    && $stable(rsp_bp_side) && $stable(rsp_last_result)))
      else $error("waiting result changed");

endmodule
